/* design/prltm_pkg.sv */
package prltm_pkg;

  localparam int SEQ_W   = 32;
  localparam int BYTES_W = 16;
  localparam int TIME_W  = 48;
  localparam int CNT_W   = 32;
  localparam int RATE_W  = 40;
  localparam int LOSS_W  = 16;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd100000000;
  localparam logic [29:0]       NS_PER_S     = 30'd1000000000;

  // register byte offsets
  localparam logic [3:0] REG_WARMUP = 4'h0;
  localparam logic [3:0] REG_WINDOW = 4'h8;

  // classified work item handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]  packet_count;
    logic [TIME_W-1:0] delay_ns;
    logic [TIME_W-1:0] gap_ns;
    logic [RATE_W-1:0] wbytes;    // window bytes including this packet
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  lost;
    logic [SEQ_W:0]    seq_p1;    // seq_id + 1
  } prltm_work_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } prltm_bk_state_t;

endpackage

/* design/packet_rx_loss_throughput_monitor.sv */
// a result passes through the queue, the multiply, the divide and the output states in that order
// the back takes a new item only once the previous result has left, held busy by the 4-bit-per-cycle divider
// packets inside warmup update the counters but give no result
// reset: synchronous active-low rst_n clears counters, window and queue;
// warmup_time resets to 0, window_length to 100000000
module packet_rx_loss_throughput_monitor import prltm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SEQ_W-1:0]   in_seq_id,
  input  logic [BYTES_W-1:0] in_payload_bytes,
  input  logic [TIME_W-1:0]  in_sent_time,
  input  logic [TIME_W-1:0]  in_arrival_time,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   out_packet_count,
  output logic [TIME_W-1:0]  out_delay_ns,
  output logic [TIME_W-1:0]  out_gap_ns,
  output logic [RATE_W-1:0]  out_window_rate,
  output logic [LOSS_W-1:0]  out_loss_fraction
);

  logic [TIME_W-1:0] warmup_time_r;
  logic [TIME_W-1:0] window_length_r;
  logic              q_valid;
  logic              q_stall;
  prltm_work_t       q_data;

  assign pready = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_time_r   <= '0;
      window_length_r <= WINDOW_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_WARMUP) warmup_time_r   <= pwdata[TIME_W-1:0];
      if (paddr == REG_WINDOW) window_length_r <= pwdata[TIME_W-1:0];
    end
  end

  always_comb begin
    priority if (paddr == REG_WARMUP) prdata = {16'd0, warmup_time_r};
    else if (paddr == REG_WINDOW)     prdata = {16'd0, window_length_r};
    else                              prdata = '0;
  end

  // front: sequence tracking, counters, window bookkeeping
  prltm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .warmup_time      (warmup_time_r),
    .window_length    (window_length_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seq_id        (in_seq_id),
    .in_payload_bytes (in_payload_bytes),
    .in_sent_time     (in_sent_time),
    .in_arrival_time  (in_arrival_time),
    .q_valid          (q_valid),
    .q_stall          (q_stall),
    .q_data           (q_data)
  );

  // back: rate and loss division, result register
  prltm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_stall           (q_stall),
    .q_data            (q_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_count  (out_packet_count),
    .out_delay_ns      (out_delay_ns),
    .out_gap_ns        (out_gap_ns),
    .out_window_rate   (out_window_rate),
    .out_loss_fraction (out_loss_fraction)
  );

endmodule

/* design/prltm_front.sv */
module prltm_front import prltm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TIME_W-1:0] warmup_time,
  input  logic [TIME_W-1:0] window_length,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SEQ_W-1:0]  in_seq_id,
  input  logic [BYTES_W-1:0] in_payload_bytes,
  input  logic [TIME_W-1:0] in_sent_time,
  input  logic [TIME_W-1:0] in_arrival_time,
  output logic              q_valid,
  input  logic              q_stall,
  output prltm_work_t       q_data
);

  logic               seen_first_r;
  logic [SEQ_W-1:0]   highest_seq_r;
  logic [CNT_W-1:0]   lost_count_r;
  logic [CNT_W-1:0]   received_count_r;
  logic [TIME_W-1:0]  last_arrival_r;
  logic [RATE_W-1:0]  window_bytes_r;
  logic [TIME_W-1:0]  window_start_r;

  logic               full_r;
  prltm_work_t        slot_r;

  logic               acc;
  logic [SEQ_W:0]     hi_p1;
  logic [SEQ_W:0]     jump;
  logic [CNT_W:0]     lost_sum;
  logic [CNT_W-1:0]   lost_nxt;
  logic [SEQ_W-1:0]   highest_nxt;
  logic [CNT_W-1:0]   recv_nxt;
  logic               emit;
  logic [RATE_W:0]    wb_sum;
  logic [RATE_W-1:0]  wb_nxt;
  logic [TIME_W-1:0]  elapsed;

  // one-entry queue; accepts when empty or draining
  assign in_stall = full_r && q_stall;
  assign acc      = in_valid && !in_stall;
  assign q_valid  = full_r;
  assign q_data   = slot_r;

  always_comb begin
    hi_p1       = {1'b0, highest_seq_r} + 33'd1;
    jump        = {1'b0, in_seq_id} - hi_p1;
    lost_sum    = {1'b0, lost_count_r} + jump;
    lost_nxt    = lost_count_r;
    highest_nxt = highest_seq_r;
    if (!seen_first_r) begin
      highest_nxt = in_seq_id;
    end else if ({1'b0, in_seq_id} > hi_p1) begin
      lost_nxt    = lost_sum[CNT_W] ? {CNT_W{1'b1}} : lost_sum[CNT_W-1:0];
      highest_nxt = in_seq_id;
    end else if (in_seq_id >= highest_seq_r) begin
      highest_nxt = in_seq_id;
    end
    recv_nxt = (&received_count_r) ? received_count_r : received_count_r + 32'd1;
    emit     = in_arrival_time > warmup_time;
    wb_sum   = {1'b0, window_bytes_r} + {{(RATE_W+1-BYTES_W){1'b0}}, in_payload_bytes};
    wb_nxt   = wb_sum[RATE_W] ? {RATE_W{1'b1}} : wb_sum[RATE_W-1:0];
    elapsed  = (in_arrival_time > window_start_r) ? in_arrival_time - window_start_r
                                                  : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r     <= 1'b0;
      highest_seq_r    <= '0;
      lost_count_r     <= '0;
      received_count_r <= '0;
      last_arrival_r   <= '0;
      window_bytes_r   <= '0;
      window_start_r   <= '0;
      full_r           <= 1'b0;
    end else begin
      if (acc && emit) full_r <= 1'b1;
      else if (full_r && !q_stall) full_r <= 1'b0;
      if (acc) begin
        seen_first_r     <= 1'b1;
        highest_seq_r    <= highest_nxt;
        lost_count_r     <= lost_nxt;
        received_count_r <= recv_nxt;
        if (emit) begin
          last_arrival_r <= in_arrival_time;
          if (elapsed >= window_length) begin
            window_bytes_r <= '0;
            window_start_r <= in_arrival_time;
          end else begin
            window_bytes_r <= wb_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      slot_r.packet_count <= recv_nxt;
      slot_r.delay_ns     <= (in_arrival_time > in_sent_time)
                             ? in_arrival_time - in_sent_time : '0;
      slot_r.gap_ns       <= (last_arrival_r != '0 && in_arrival_time > last_arrival_r)
                             ? in_arrival_time - last_arrival_r : '0;
      slot_r.wbytes       <= wb_nxt;
      slot_r.elapsed      <= elapsed;
      slot_r.lost         <= lost_nxt;
      slot_r.seq_p1       <= {1'b0, in_seq_id} + 33'd1;
    end
  end

endmodule

/* design/prltm_back.sv */
module prltm_back import prltm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_stall,
  input  prltm_work_t       q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  out_packet_count,
  output logic [TIME_W-1:0] out_delay_ns,
  output logic [TIME_W-1:0] out_gap_ns,
  output logic [RATE_W-1:0] out_window_rate,
  output logic [LOSS_W-1:0] out_loss_fraction
);

  localparam int NUM_W = 72;            // bytes * 1e9 fits in 70 bits, padded to STEPS
  localparam int LN_W  = CNT_W + LOSS_W;
  localparam int STEPS = 4;             // quotient bits per cycle

  prltm_bk_state_t state_r, state_nxt;
  prltm_work_t     w_r;
  logic [NUM_W-1:0]  num_r;
  logic [TIME_W:0]   rem_r;
  logic [RATE_W-1:0] q_r;
  logic              rsat_r;
  logic [LN_W-1:0]   lnum_r;
  logic [SEQ_W+1:0]  lrem_r;
  logic [LN_W-1:0]   lq_r;
  logic [6:0]        cnt_r;
  logic [NUM_W-1:0]  prod_lo_r, prod_hi_r;

  logic [NUM_W-1:0]  num_v;
  logic [TIME_W:0]   rem_v;
  logic [RATE_W-1:0] q_v;
  logic              rsat_v;
  logic [LN_W-1:0]   lnum_v;
  logic [SEQ_W+1:0]  lrem_v;
  logic [LN_W-1:0]   lq_v;
  logic              take;

  assign take    = q_valid && (state_r == BK_IDLE);
  assign q_stall = (state_r != BK_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == 7'd0) state_nxt = BK_OUT;
      BK_OUT:  if (!out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // restoring division, STEPS quotient bits per cycle for both quotients
  always_comb begin
    num_v  = num_r;
    rem_v  = rem_r;
    q_v    = q_r;
    rsat_v = rsat_r;
    lnum_v = lnum_r;
    lrem_v = lrem_r;
    lq_v   = lq_r;
    for (int k = 0; k < STEPS; k++) begin
      rem_v = {rem_v[TIME_W-1:0], num_v[NUM_W-1]};
      num_v = {num_v[NUM_W-2:0], 1'b0};
      if (rem_v >= {1'b0, w_r.elapsed}) begin
        rem_v = rem_v - {1'b0, w_r.elapsed};
        if (q_v[RATE_W-1]) rsat_v = 1'b1;
        q_v = {q_v[RATE_W-2:0], 1'b1};
      end else begin
        if (q_v[RATE_W-1]) rsat_v = 1'b1;
        q_v = {q_v[RATE_W-2:0], 1'b0};
      end
      lrem_v = {lrem_v[SEQ_W:0], lnum_v[LN_W-1]};
      lnum_v = {lnum_v[LN_W-2:0], 1'b0};
      if (lrem_v >= {1'b0, w_r.seq_p1}) begin
        lrem_v = lrem_v - {1'b0, w_r.seq_p1};
        lq_v   = {lq_v[LN_W-2:0], 1'b1};
      end else begin
        lq_v   = {lq_v[LN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: if (take) begin
        w_r       <= q_data;
        // split multiply: 32x30 and 8x30
        prod_lo_r <= NUM_W'(q_data.wbytes[31:0]) * NUM_W'(NS_PER_S);
        prod_hi_r <= NUM_W'(q_data.wbytes[RATE_W-1:32]) * NUM_W'(NS_PER_S);
      end
      BK_MUL: begin
        num_r  <= prod_lo_r + (prod_hi_r << 32);
        rem_r  <= '0;
        q_r    <= '0;
        rsat_r <= 1'b0;
        lnum_r <= {w_r.lost, {LOSS_W{1'b0}}};
        lrem_r <= '0;
        lq_r   <= '0;
        cnt_r  <= 7'(NUM_W / STEPS - 1);
      end
      BK_DIV: begin
        num_r  <= num_v;
        rem_r  <= rem_v;
        q_r    <= q_v;
        rsat_r <= rsat_v;
        // loss dividend is shorter; shift it only once the count drops below LN_W / STEPS
        if (cnt_r < 7'(LN_W / STEPS)) begin
          lnum_r <= lnum_v;
          lrem_r <= lrem_v;
          lq_r   <= lq_v;
        end
        cnt_r  <= cnt_r - 7'd1;
      end
      BK_OUT: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid         = (state_r == BK_OUT);
    out_packet_count  = w_r.packet_count;
    out_delay_ns      = w_r.delay_ns;
    out_gap_ns        = w_r.gap_ns;
    if (w_r.elapsed == '0)     out_window_rate = '0;
    else if (rsat_r)           out_window_rate = {RATE_W{1'b1}};
    else                       out_window_rate = q_r;
    out_loss_fraction = (|lq_r[LN_W-1:LOSS_W]) ? {LOSS_W{1'b1}} : lq_r[LOSS_W-1:0];
  end

endmodule
